FILE: hdl/utf8_to_utf16_transcoder_assert.svh
// Assertion macros used by the checker of the transcoder.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/u8u16_pkg.sv
// Shared types, constants and the lead byte length function of the transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    // Longest sequence any configuration may use; job storage is sized by it.
    localparam int SEQ_LIMIT   = 6;
    localparam int FLUSH_SLOTS = SEQ_LIMIT - 1;

    // Job queue between the front and back parts. The depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  CONT_MASK    = 8'hC0;
    localparam logic [7:0]  CONT_TAG     = 8'h80;
    localparam logic [7:0]  LEAD_MASK    = 8'h7F;
    localparam logic [15:0] SURR_HI_BASE = 16'hD7C0;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [31:0] PLANE_ONE    = 32'h0001_0000;

    // One result beat as it leaves the block.
    typedef struct packed {
        logic [15:0] code;
        logic        tail_flag;
        logic [2:0]  left;
    } t_beat;

    // Work for one accepted byte: held bytes to flush first, then up to two
    // finished beats (a unit, a surrogate pair or the end status).
    typedef struct packed {
        logic [2:0]                  flush_cnt;
        logic [FLUSH_SLOTS-1:0][7:0] flush;
        logic [1:0]                  tail_cnt;
        t_beat [1:0]                 tail;
    } t_job;

    // Sequence length announced by a byte; 1 for anything that opens nothing.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'hC0) begin
            len = 3'd1;
        end else if (b < 8'hE0) begin
            len = 3'd2;
        end else if (b < 8'hF0) begin
            len = 3'd3;
        end else if (b < 8'hF8) begin
            len = 3'd4;
        end else if (b < 8'hFC) begin
            len = 3'd5;
        end else if (b < 8'hFE) begin
            len = 3'd6;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

endpackage

FILE: hdl/u8u16_front.sv
// Front part: holds the open sequence, classifies each byte and builds its job.
`timescale 1ns / 1ps

module u8u16_front #(
    parameter int MAX_SEQUENCE_BYTES = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_text,
    output logic            o_push,
    output u8u16_pkg::t_job o_job
);

    localparam int HELD_DEPTH = MAX_SEQUENCE_BYTES - 1;
    localparam int VW         = 5 * MAX_SEQUENCE_BYTES + 1;

    logic [HELD_DEPTH-1:0][7:0] r_held, n_held;
    logic [2:0]                 r_exp, n_exp;
    logic [2:0]                 r_cnt, n_cnt;

    logic [2:0]    len_raw, len;
    logic          is_cont;
    logic [VW-1:0] acc, dec;
    logic          big;
    logic [15:0]   surr_hi, surr_lo;
    u8u16_pkg::t_job job;

    assign len_raw = u8u16_pkg::lead_len(i_data_byte);
    assign len     = (len_raw > 3'(MAX_SEQUENCE_BYTES)) ? 3'd1 : len_raw;
    assign is_cont = (i_data_byte & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG;

    // Assemble the value for every possible length; the open length selects.
    always_comb begin
        acc = '0;
        dec = '0;
        for (int l = 2; l <= MAX_SEQUENCE_BYTES; l++) begin
            acc = VW'(r_held[0] & (u8u16_pkg::LEAD_MASK >> l));
            for (int i = 1; i < l - 1; i++) begin
                acc = (acc << 6) | VW'(r_held[i][5:0]);
            end
            acc = (acc << 6) | VW'(i_data_byte[5:0]);
            if (r_exp == 3'(l)) begin
                dec = acc;
            end
        end
    end

    assign big     = dec >= VW'(u8u16_pkg::PLANE_ONE);
    assign surr_hi = 16'(VW'(u8u16_pkg::SURR_HI_BASE) + (dec >> 10));
    assign surr_lo = u8u16_pkg::SURR_LO_BASE | {6'd0, dec[9:0]};

    always_comb begin
        n_held = r_held;
        n_exp  = r_exp;
        n_cnt  = r_cnt;
        job    = '0;

        if ((r_exp != 3'd0) && is_cont) begin
            if (3'(r_cnt + 3'd1) == r_exp) begin
                if (big) begin
                    job.tail[0].code = surr_hi;
                    job.tail[1].code = surr_lo;
                    job.tail_cnt     = 2'd2;
                end else begin
                    job.tail[0].code = dec[15:0];
                    job.tail_cnt     = 2'd1;
                end
                n_exp = 3'd0;
                n_cnt = 3'd0;
            end else begin
                for (int j = 0; j < HELD_DEPTH; j++) begin
                    if (r_cnt == 3'(j)) begin
                        n_held[j] = i_data_byte;
                    end
                end
                n_cnt = 3'(r_cnt + 3'd1);
            end
        end else begin
            // A broken sequence gives back its held bytes before the new byte.
            if (r_exp != 3'd0) begin
                job.flush_cnt = r_cnt;
                for (int j = 0; j < HELD_DEPTH; j++) begin
                    job.flush[j] = r_held[j];
                end
            end
            if (len == 3'd1) begin
                job.tail[0].code = {8'd0, i_data_byte};
                job.tail_cnt     = 2'd1;
                n_exp            = 3'd0;
                n_cnt            = 3'd0;
            end else begin
                n_held[0] = i_data_byte;
                n_cnt     = 3'd1;
                n_exp     = len;
            end
        end

        // Text ends inside a sequence: report and drop what is held.
        if (i_end_of_text && (n_exp != 3'd0)) begin
            job.tail[0].code      = 16'd0;
            job.tail[0].tail_flag = 1'b1;
            job.tail[0].left      = n_cnt;
            job.tail_cnt          = 2'd1;
            n_exp                 = 3'd0;
            n_cnt                 = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= 3'd0;
            r_cnt <= 3'd0;
        end else if (i_accept) begin
            r_exp <= n_exp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && ((job.flush_cnt != 3'd0) || (job.tail_cnt != 2'd0));

endmodule

FILE: hdl/u8u16_queue.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps

module u8u16_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8u16_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output u8u16_pkg::t_job o_head
);

    u8u16_pkg::t_job r_mem [u8u16_pkg::QUEUE_DEPTH];

    logic [u8u16_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [u8u16_pkg::QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full     = r_count == u8u16_pkg::QCNT_W'(u8u16_pkg::QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_mem[r_rp];

endmodule

FILE: hdl/u8u16_back.sv
// Back part: unrolls each job into result beats through the output register.
`timescale 1ns / 1ps

module u8u16_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8u16_pkg::t_job i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_code_unit,
    output logic            o_incomplete_tail,
    output logic [2:0]      o_leftover_bytes,
    output logic            o_last_of_run
);

    logic            r_busy;
    u8u16_pkg::t_job r_job;
    logic            r_valid;
    u8u16_pkg::t_beat r_beat;
    logic            r_last;

    u8u16_pkg::t_job  cur, rem;
    u8u16_pkg::t_beat beat;
    logic             have, out_free, step, last;

    assign cur      = r_busy ? r_job : i_head;
    assign have     = r_busy || i_head_valid;
    assign out_free = !r_valid || !i_stall;
    assign step     = out_free && have;
    assign last     = (4'(cur.flush_cnt) + 4'(cur.tail_cnt)) == 4'd1;

    // Flushed bytes go out first, then the finished beats, one per cycle unless the output stalls.
    always_comb begin
        rem  = cur;
        beat = '0;
        if (cur.flush_cnt != 3'd0) begin
            beat.code = {8'd0, cur.flush[0]};
            for (int k = 0; k < u8u16_pkg::FLUSH_SLOTS - 1; k++) begin
                rem.flush[k] = cur.flush[k+1];
            end
            rem.flush[u8u16_pkg::FLUSH_SLOTS-1] = 8'd0;
            rem.flush_cnt = cur.flush_cnt - 3'd1;
        end else begin
            beat         = cur.tail[0];
            rem.tail[0]  = cur.tail[1];
            rem.tail[1]  = '0;
            rem.tail_cnt = cur.tail_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= have;
            if (step) begin
                r_busy <= !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_job  <= rem;
            r_beat <= beat;
            r_last <= last;
        end
    end

    assign o_pop             = step && !r_busy;
    assign o_valid           = r_valid;
    assign o_code_unit       = r_beat.code;
    assign o_incomplete_tail = r_beat.tail_flag;
    assign o_leftover_bytes  = r_beat.left;
    assign o_last_of_run     = r_last;

endmodule

FILE: hdl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   Channel | Direction | Handshake          | Beat payload
//   --------+-----------+--------------------+-------------------------------------------
//   input   | in        | i_valid / o_stall  | i_data_byte, i_end_of_text
//   output  | out       | o_valid / i_stall  | o_code_unit, o_incomplete_tail,
//           |           |                    | o_leftover_bytes, o_last_of_run
//
// One input beat is taken per cycle while the job queue has room; every byte is
// classified in the cycle it is taken. Each byte yields zero to six output beats,
// and the back part sends one beat per cycle unless the output stalls, so the
// sustained rate is one byte per cycle for plain text. A result passes through
// the job queue and then the output register before it shows up on the output.
// Reset is synchronous and active low; it closes any open sequence and empties
// the queue and the output register. o_stall rises only when the queue is full,
// and an output stall holds the output register and then backs up the queue.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder #(
    parameter int MAX_SEQUENCE_BYTES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic        o_incomplete_tail,
    output logic [2:0]  o_leftover_bytes,
    output logic        o_last_of_run
);

    logic            accept;
    logic            push, pop, full, nonempty;
    u8u16_pkg::t_job push_job, head_job;

    // A byte is taken whenever the queue can hold its job, whatever the
    // output side is doing.
    assign accept  = i_valid && !full;
    assign o_stall = full;

    u8u16_front #(
        .MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_end_of_text(i_end_of_text),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Bytes that only extend a sequence produce no job and skip the queue.
    u8u16_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_job     (push_job),
        .i_pop     (pop),
        .o_full    (full),
        .o_nonempty(nonempty),
        .o_head    (head_job)
    );

    // The back part takes a job straight from the queue head, so a job of
    // one beat leaves the queue as its beat is sent.
    u8u16_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_head_valid     (nonempty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_unit      (o_code_unit),
        .o_incomplete_tail(o_incomplete_tail),
        .o_leftover_bytes (o_leftover_bytes),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

FILE: hdl/u8u16_checker.sv
// Port-level checks of the transcoder and the bind that attaches them.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_assert.svh"

module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_code_unit,
    input logic        o_incomplete_tail,
    input logic [2:0]  o_leftover_bytes,
    input logic        o_last_of_run
);

    `U8U16_ASSERT_NEXT(a_out_valid_holds, o_valid && i_stall, o_valid, "output beat dropped while stalled")
    `U8U16_ASSERT_NEXT(a_out_payload_holds, o_valid && i_stall, $stable({o_code_unit, o_incomplete_tail, o_leftover_bytes, o_last_of_run}), "stalled output beat changed")
    `U8U16_ASSERT_NOW(a_status_shape, o_valid && o_incomplete_tail, o_last_of_run && (o_code_unit == 16'd0) && (o_leftover_bytes != 3'd0), "end status beat malformed")
    `U8U16_ASSERT_NOW(a_unit_no_leftover, o_valid && !o_incomplete_tail, o_leftover_bytes == 3'd0, "leftover count on a code unit beat")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_code_unit      (o_code_unit),
    .o_incomplete_tail(o_incomplete_tail),
    .o_leftover_bytes (o_leftover_bytes),
    .o_last_of_run    (o_last_of_run)
);

FILE: test/utf8_to_utf16_transcoder_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder, with random stalls on both sides.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_test;

    // The sequence limit the block is built with; leads longer than this pass through as strays.
    localparam int MAX_SEQ      = 6;
    // Random bytes that follow the directed script.
    localparam int RANDOM_BYTES = 146;
    // Idle chance per cycle on each side, in percent.
    localparam int IDLE_PCT     = 17;
    // Quiet cycles after the last expected beat, to catch extra output.
    localparam int DRAIN_CYCLES = 20;

    // How a stimulus row is checked. Rows whose outcome is obvious carry it typed in.
    // All other rows take their expectation from the predictor.
    typedef enum logic [1:0] {
        CHECK_MODEL,
        EXPECT_NOTHING,
        EXPECT_UNIT
    } t_check;

    typedef struct packed {
        logic [7:0]  data;
        logic        eot;
        t_check      mode;
        logic [15:0] code;
        logic        tail;
        logic [2:0]  left;
    } t_row;

    // One output beat as the checker sees it.
    typedef struct packed {
        logic [15:0] code;
        logic        tail;
        logic [2:0]  left;
        logic        last;
    } t_unit;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_code_unit;
    logic        o_incomplete_tail;
    logic [2:0]  o_leftover_bytes;
    logic        o_last_of_run;

    // Directed script covers:
    // - the extremes of the byte range;
    // - stray continuation bytes and the two never-lead bytes;
    // - end of text inside a sequence;
    // - an overlong encoding;
    // - a surrogate pair;
    // - the largest six-byte value;
    // - a sequence broken by a plain byte;
    // - end of text after a partial six-byte sequence.
    t_row script [24] = '{
        '{8'h00, 1'b0, EXPECT_UNIT,    16'h0000, 1'b0, 3'd0},
        '{8'h7F, 1'b0, EXPECT_UNIT,    16'h007F, 1'b0, 3'd0},
        '{8'h80, 1'b0, EXPECT_UNIT,    16'h0080, 1'b0, 3'd0},
        '{8'hFF, 1'b0, EXPECT_UNIT,    16'h00FF, 1'b0, 3'd0},
        '{8'hFE, 1'b1, EXPECT_UNIT,    16'h00FE, 1'b0, 3'd0},
        '{8'hE2, 1'b1, EXPECT_UNIT,    16'h0000, 1'b1, 3'd1},
        '{8'hC0, 1'b0, EXPECT_NOTHING, 16'h0000, 1'b0, 3'd0},
        '{8'h80, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hF0, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h9F, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h98, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h80, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hFD, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hBF, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hBF, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hBF, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hBF, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hBF, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hF8, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h80, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h41, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'hFC, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h80, 1'b0, CHECK_MODEL,    16'h0000, 1'b0, 3'd0},
        '{8'h80, 1'b1, CHECK_MODEL,    16'h0000, 1'b0, 3'd0}
    };

    // Bytes still to be sent, and beats still to be received, in order.
    t_row  text_q[$];
    t_unit pending_units[$];
    // Beats that the predictor produced for the byte it was last given.
    t_unit byte_units[$];

    // Predictor state: the open sequence, its length (zero when none is open),
    // and how many of its bytes have arrived so far.
    logic [7:0] seq_bytes [0:MAX_SEQ-1];
    logic [2:0] seq_len;
    logic [2:0] seq_held;

    // While this is set, neither side idles, so the block runs at full rate.
    logic calm = 1'b0;

    int random_bytes = 0;
    int bytes_sent   = 0;
    int beats_seen   = 0;
    int pairs_seen   = 0;
    int tails_seen   = 0;
    int mismatches   = 0;

    utf8_to_utf16_transcoder #(
        .MAX_SEQUENCE_BYTES(MAX_SEQ)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_text    (i_end_of_text),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_unit      (o_code_unit),
        .o_incomplete_tail(o_incomplete_tail),
        .o_leftover_bytes (o_leftover_bytes),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sequence length that a byte opens. Anything that opens nothing, or opens a
    // sequence longer than the build allows, counts as length one.
    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] n;
        casez (b)
            8'b110?_????: n = 3'd2;
            8'b1110_????: n = 3'd3;
            8'b1111_0???: n = 3'd4;
            8'b1111_10??: n = 3'd5;
            8'b1111_110?: n = 3'd6;
            default:      n = 3'd1;
        endcase
        if (n > MAX_SEQ) begin
            n = 3'd1;
        end
        return n;
    endfunction

    task automatic add_unit(input logic [15:0] code, input logic tail, input logic [2:0] left);
        t_unit u;
        u = '{code, tail, left, 1'b0};
        byte_units.insert(byte_units.size(), u);
    endtask

    // A byte seen with no sequence open either passes through as a unit or opens a sequence.
    task automatic open_or_pass(input logic [7:0] b);
        logic [2:0] n;
        n = seq_length(b);
        if (n == 3'd1) begin
            add_unit({8'h00, b}, 1'b0, 3'd0);
        end else begin
            seq_bytes[0] = b;
            seq_held     = 3'd1;
            seq_len      = n;
        end
    endtask

    // Works out every beat that one byte causes and advances the predictor state.
    task automatic transcode_byte(input logic [7:0] b, input logic eot);
        logic [31:0] cp;
        logic [31:0] hi_word;
        t_unit       final_unit;
        byte_units.delete();
        if (seq_len != 3'd0) begin
            if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG) begin
                seq_bytes[seq_held] = b;
                seq_held = seq_held + 3'd1;
                if (seq_held >= seq_len) begin
                    // The lead keeps only the payload bits that sit below its length marker.
                    cp = {24'd0, seq_bytes[0] & (8'h7F >> seq_len)};
                    for (int k = 1; k < seq_len; k++) begin
                        cp = (cp << 6) | {26'd0, seq_bytes[k][5:0]};
                    end
                    if (cp >= u8u16_pkg::PLANE_ONE) begin
                        // Values beyond the last plane wrap; both halves are taken mod 2^16.
                        hi_word = {16'd0, u8u16_pkg::SURR_HI_BASE} + (cp >> 10);
                        add_unit(hi_word[15:0], 1'b0, 3'd0);
                        add_unit(u8u16_pkg::SURR_LO_BASE | {6'd0, cp[9:0]}, 1'b0, 3'd0);
                        pairs_seen++;
                    end else begin
                        add_unit(cp[15:0], 1'b0, 3'd0);
                    end
                    seq_len  = 3'd0;
                    seq_held = 3'd0;
                end
            end else begin
                // A broken sequence gives back its held bytes one by one, lead first.
                for (int k = 0; k < seq_held; k++) begin
                    add_unit({8'h00, seq_bytes[k]}, 1'b0, 3'd0);
                end
                seq_len  = 3'd0;
                seq_held = 3'd0;
                open_or_pass(b);
            end
        end else begin
            open_or_pass(b);
        end
        if (eot && seq_len != 3'd0) begin
            add_unit(16'h0000, 1'b1, seq_held);
            seq_len  = 3'd0;
            seq_held = 3'd0;
        end
        if (byte_units.size() != 0) begin
            final_unit = byte_units.pop_back();
            final_unit.last = 1'b1;
            byte_units.insert(byte_units.size(), final_unit);
        end
    endtask

    // Called at the edge where a byte is taken: queue what it must produce.
    task automatic accept_byte(input t_row row);
        t_unit u;
        transcode_byte(row.data, row.eot);
        case (row.mode)
            CHECK_MODEL: begin
                foreach (byte_units[k]) begin
                    pending_units.insert(pending_units.size(), byte_units[k]);
                end
            end
            EXPECT_UNIT: begin
                u = '{row.code, row.tail, row.left, 1'b1};
                pending_units.insert(pending_units.size(), u);
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] data, input logic eot);
        t_row r;
        r = '{data, eot, CHECK_MODEL, 16'h0000, 1'b0, 3'd0};
        text_q.insert(text_q.size(), r);
        random_bytes++;
    endtask

    function automatic logic [7:0] random_lead(input int n);
        logic [7:0] b;
        case (n)
            1:       b = 8'($urandom_range(8'h00, 8'h7F));
            2:       b = 8'($urandom_range(8'hC0, 8'hDF));
            3:       b = 8'($urandom_range(8'hE0, 8'hEF));
            4:       b = 8'($urandom_range(8'hF0, 8'hF7));
            5:       b = 8'($urandom_range(8'hF8, 8'hFB));
            default: b = 8'($urandom_range(8'hFC, 8'hFD));
        endcase
        return b;
    endfunction

    // Random text: mostly well-formed sequences of every length with random payload,
    // mixed with sequences cut short (some at end of text) and loose noise bytes.
    task automatic build_random_text();
        int pick;
        int n;
        int cut;
        while (random_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: n = 1;
                    4, 5:       n = 2;
                    6:          n = 3;
                    7:          n = 4;
                    8:          n = 5;
                    default:    n = 6;
                endcase
                add_byte(random_lead(n), n == 1 && $urandom_range(0, 9) == 0);
                for (int k = 1; k < n; k++) begin
                    add_byte(8'($urandom_range(8'h80, 8'hBF)),
                             k == n - 1 && $urandom_range(0, 9) == 0);
                end
            end else if (pick < 88) begin
                n   = $urandom_range(2, 6);
                cut = $urandom_range(0, n - 2);
                add_byte(random_lead(n), cut == 0 && $urandom_range(0, 1) == 1);
                for (int k = 1; k <= cut; k++) begin
                    add_byte(8'($urandom_range(8'h80, 8'hBF)),
                             k == cut && $urandom_range(0, 1) == 1);
                end
            end else begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Sender: presents each byte on a falling edge, idles at random in between,
    // and holds the beat steady until a rising edge finds o_stall low.
    initial begin : drive_bytes
        t_row row;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = 8'h00;
        i_end_of_text = 1'b0;
        seq_len       = 3'd0;
        seq_held      = 3'd0;

        foreach (script[k]) begin
            text_q.insert(text_q.size(), script[k]);
        end
        build_random_text();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0) begin
            row = text_q.pop_front();
            // A stretch in the middle of the random text runs with no idling on either side.
            calm <= (bytes_sent >= 80 && bytes_sent < 130);
            // Each cycle before the beat idles with the same chance.
            while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_valid       <= 1'b1;
            i_data_byte   <= row.data;
            i_end_of_text <= row.eot;
            @(posedge i_clk);
            while (o_stall) begin
                @(posedge i_clk);
            end
            accept_byte(row);
            bytes_sent++;
            @(negedge i_clk);
        end
        i_valid <= 1'b0;

        // Drain: every predicted beat must arrive, then nothing more may follow.
        while (pending_units.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d directed), checked %0d beats.",
                 bytes_sent, $size(script), beats_seen);
        $display("Surrogate pairs predicted: %0d; end-of-text status beats: %0d; mismatches: %0d.",
                 pairs_seen, tails_seen, mismatches);
        if (mismatches == 0) begin
            $display("utf8_to_utf16_transcoder_test: clean");
        end else begin
            $display("utf8_to_utf16_transcoder_test: errors");
        end
        $finish;
    end

    // Receiver: stalls at random, changing only on falling edges.
    initial begin : drive_stall
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Checker: every beat taken must match the oldest pending expectation, field by field.
    always @(posedge i_clk) begin : check_beats
        t_unit want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen++;
            if (pending_units.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: beat with nothing expected: unit %h tail %b left %0d last %b",
                             $realtime, o_code_unit, o_incomplete_tail, o_leftover_bytes,
                             o_last_of_run);
                end
            end else begin
                want = pending_units.pop_front();
                if (want.tail) begin
                    tails_seen++;
                end
                if (o_code_unit !== want.code || o_incomplete_tail !== want.tail ||
                    o_leftover_bytes !== want.left || o_last_of_run !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected unit %h tail %b left %0d last %b, got %h %b %0d %b",
                                 $realtime, want.code, want.tail, want.left, want.last,
                                 o_code_unit, o_incomplete_tail, o_leftover_bytes,
                                 o_last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Timed out with %0d beats still expected.", pending_units.size());
        $display("utf8_to_utf16_transcoder_test: errors");
        $finish;
    end

endmodule

FILE: utf8_to_utf16_transcoder.f
+incdir+hdl
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_queue.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_transcoder.sv
hdl/u8u16_checker.sv
test/utf8_to_utf16_transcoder_test.sv
